@@ rtl/cscq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cscq_pkg: shared constants, types and tables of the CORDIC sine/cosine core
//
// Holds the angle unit constants, the widths derived from them, the constant
// reciprocal used for the period reduction, the arctangent table and the
// structures passed between the pipeline sections.
// ----------------------------------------------------------------------------
package cscq_pkg;

   // Angle units: one full period, half and quarter of it.
   localparam int ANGLE_PERIOD  = 25736;
   localparam int ANGLE_HALF    = 12868;
   localparam int ANGLE_QUARTER = 6434;

   // Number of CORDIC rotation steps, from 1 to 13.
   localparam int ITERATIONS = 13;

   // Port field widths.
   localparam int ANGLE_W = 32;
   localparam int OUT_W   = 16;

   // Width of a remainder of the period.
   localparam int NABS_W = $clog2(ANGLE_PERIOD);
   localparam int HALF_W = $clog2(ANGLE_HALF + 1);
   localparam int BASE_W = ((NABS_W > HALF_W) ? NABS_W : HALF_W) + 3;

   // Signed width of the normalised and folded angle and the angle accumulator.
   localparam int ANG_W = (BASE_W > 16) ? BASE_W : 16;

   // Constant reciprocal of the period: q = (mag * RECIP) >> RECIP_SHIFT is the
   // true quotient or one less, for any 32-bit magnitude.
   localparam int              RECIP_SHIFT = 46;
   localparam logic [63:0]     RECIP_WIDE  = (64'd1 << RECIP_SHIFT) / 64'(ANGLE_PERIOD);
   localparam int              RECIP_W     = $clog2(RECIP_WIDE + 64'd1);
   localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_WIDE);
   localparam int              PROD_W      = ANGLE_W + RECIP_W;
   localparam int              Q_W         = ANGLE_W + 1 - NABS_W;
   localparam int              QC_W        = Q_W + NABS_W;

   // Signed copies of the angle constants at the working width.
   localparam logic signed [ANG_W-1:0] PERIOD_S  = ANG_W'(ANGLE_PERIOD);
   localparam logic signed [ANG_W-1:0] HALF_S    = ANG_W'(ANGLE_HALF);
   localparam logic signed [ANG_W-1:0] QUARTER_S = ANG_W'(ANGLE_QUARTER);

   // Q14 values and gain correction.
   localparam logic signed [OUT_W-1:0] ONE_Q14   = 16'sh4000;
   localparam logic        [15:0]      GAIN      = 16'h9b75;
   localparam logic signed [32:0]      GAIN_ROUND = 33'sh0_0000_8000;

   // Arctangent of 2^-i in angle units.
   function automatic logic signed [ANG_W-1:0] atan_step(input int idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         0:       val = ANG_W'(3217);
         1:       val = ANG_W'(1899);
         2:       val = ANG_W'(1003);
         3:       val = ANG_W'(509);
         4:       val = ANG_W'(256);
         5:       val = ANG_W'(128);
         6:       val = ANG_W'(64);
         7:       val = ANG_W'(32);
         8:       val = ANG_W'(16);
         9:       val = ANG_W'(8);
         10:      val = ANG_W'(4);
         11:      val = ANG_W'(2);
         12:      val = ANG_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

   // Folded angle and the quadrant signs, from the reduction section.
   typedef struct packed {
      logic signed [ANG_W-1:0] fold;
      logic                    neg_s;
      logic                    neg_c;
   } red_type;

   // Raw rotation results with the exact-case flags and quadrant signs.
   typedef struct packed {
      logic signed [OUT_W-1:0] cos_raw;
      logic signed [OUT_W-1:0] sin_raw;
      logic                    is_zero;
      logic                    is_quarter;
      logic                    neg_s;
      logic                    neg_c;
   } rot_type;

endpackage
`default_nettype wire

@@ rtl/cscq_reduce.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cscq_reduce: period reduction and quadrant fold
//
// Six register stages: magnitude, multiply by the reciprocal of the period,
// multiply back by the period, remainder correction, normalisation into the
// closed range from minus half to half a period, and the fold into the first quadrant.
// ----------------------------------------------------------------------------
module cscq_reduce (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [31:0]      in_angle,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cscq_pkg::red_type       out_data
);

   localparam int NS = 6;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS:0]   en;

   // Stage registers.
   logic                                neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic [cscq_pkg::ANGLE_W-1:0]        mag1_ff, mag2_ff, mag3_ff;
   logic [cscq_pkg::PROD_W-1:0]         prod2_ff;
   logic [cscq_pkg::QC_W-1:0]           qc3_ff;
   logic [cscq_pkg::NABS_W-1:0]         nabs4_ff;
   logic signed [cscq_pkg::ANG_W-1:0]   norm5_ff;
   cscq_pkg::red_type                   red6_ff;

   // Next values.
   logic [cscq_pkg::ANGLE_W-1:0]        mag1_in;
   logic [cscq_pkg::PROD_W-1:0]         prod2_in;
   logic [cscq_pkg::QC_W-1:0]           qc3_in;
   logic [cscq_pkg::QC_W-1:0]           diff4;
   logic [cscq_pkg::NABS_W:0]           rem4;
   logic [cscq_pkg::NABS_W-1:0]         nabs4_in;
   logic signed [cscq_pkg::ANG_W-1:0]   nabs_s;
   logic signed [cscq_pkg::ANG_W-1:0]   norm5_in;
   cscq_pkg::red_type                   red6_in;

   localparam logic [cscq_pkg::NABS_W:0] PERIOD_R =
      (cscq_pkg::NABS_W + 1)'(cscq_pkg::ANGLE_PERIOD);

   // A stage takes a new beat when it is empty or the stage after it moves on.
   assign en[NS] = out_ready;
   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_en
         assign en[k] = ~v_ff[k] | en[k+1];
      end
   endgenerate

   assign v_in     = {v_ff[NS-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // Magnitude of the angle; the most negative angle gives 2^31 unsigned.
   assign mag1_in = in_angle[31] ? 32'(-in_angle) : 32'(in_angle);

   // Estimated quotient is exact or one short.
   assign prod2_in = cscq_pkg::PROD_W'(mag1_ff) * cscq_pkg::PROD_W'(cscq_pkg::RECIP);

   assign qc3_in = cscq_pkg::QC_W'(prod2_ff[cscq_pkg::RECIP_SHIFT +: cscq_pkg::Q_W])
                 * cscq_pkg::QC_W'(cscq_pkg::ANGLE_PERIOD);

   // Remainder below twice the period; one correcting subtraction.
   assign diff4    = {1'b0, mag3_ff} - qc3_ff;
   assign rem4     = diff4[cscq_pkg::NABS_W:0];
   assign nabs4_in = (rem4 >= PERIOD_R) ? cscq_pkg::NABS_W'(rem4 - PERIOD_R)
                                        : cscq_pkg::NABS_W'(rem4);

   // Normalise into the range around zero, equal to the angle modulo the period.
   assign nabs_s = $signed({{(cscq_pkg::ANG_W - cscq_pkg::NABS_W){1'b0}}, nabs4_ff});

   always_comb begin
      priority if (nabs_s <= cscq_pkg::HALF_S) begin
         norm5_in = neg4_ff ? -nabs_s : nabs_s;
      end else if (neg4_ff) begin
         norm5_in = cscq_pkg::PERIOD_S - nabs_s;
      end else begin
         norm5_in = nabs_s - cscq_pkg::PERIOD_S;
      end
   end

   // Fold into the first quadrant and note which results change sign.
   always_comb begin
      red6_in.neg_s = norm5_ff < 0;
      red6_in.neg_c = (norm5_ff > cscq_pkg::QUARTER_S) || (norm5_ff < -cscq_pkg::QUARTER_S);
      priority if (norm5_ff > cscq_pkg::QUARTER_S) begin
         red6_in.fold = cscq_pkg::HALF_S - norm5_ff;
      end else if (norm5_ff < -cscq_pkg::QUARTER_S) begin
         red6_in.fold = norm5_ff + cscq_pkg::HALF_S;
      end else begin
         red6_in.fold = (norm5_ff < 0) ? -norm5_ff : norm5_ff;
      end
   end

   // Payload registers move with their stage enable.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         neg1_ff <= in_angle[31];
         mag1_ff <= mag1_in;
      end
      if (en[1]) begin
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         prod2_ff <= prod2_in;
      end
      if (en[2]) begin
         neg3_ff <= neg2_ff;
         mag3_ff <= mag2_ff;
         qc3_ff  <= qc3_in;
      end
      if (en[3]) begin
         neg4_ff  <= neg3_ff;
         nabs4_ff <= nabs4_in;
      end
      if (en[4]) begin
         neg5_ff  <= neg4_ff;
         norm5_ff <= norm5_in;
      end
      if (en[5]) begin
         red6_ff <= red6_in;
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_data  = red6_ff;

   // The sign of the last stage is carried inside the fold result.
   logic unused_neg;
   assign unused_neg = neg5_ff;

endmodule
`default_nettype wire

@@ rtl/cscq_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cscq_cordic: unrolled CORDIC rotation pipeline
//
// One register stage per rotation step. Each stage steers by the sign of the
// residual angle, shifts the vector by its step index and updates the angle
// accumulator. The first stage also flags the two exact angles.
// ----------------------------------------------------------------------------
module cscq_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cscq_pkg::red_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output cscq_pkg::rot_type   out_data
);

   localparam int NI = cscq_pkg::ITERATIONS;

   logic [NI-1:0] v_ff;
   logic [NI-1:0] v_in;
   logic [NI:0]   en;

   logic signed [cscq_pkg::OUT_W-1:0] cos_ff  [NI];
   logic signed [cscq_pkg::OUT_W-1:0] sin_ff  [NI];
   logic signed [cscq_pkg::ANG_W-1:0] acc_ff  [NI];
   logic signed [cscq_pkg::ANG_W-1:0] fold_ff [NI];
   logic [NI-1:0] zero_ff;
   logic [NI-1:0] quart_ff;
   logic [NI-1:0] negs_ff;
   logic [NI-1:0] negc_ff;

   // A stage takes a new beat when it is empty or the stage after it moves on.
   assign en[NI]   = out_ready;
   assign v_in     = (NI > 1) ? {v_ff[NI-2:0], in_valid} : NI'(in_valid);
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NI; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < NI; g++) begin : g_step
         logic signed [cscq_pkg::OUT_W-1:0] c_p, s_p, cs, ss, c_in, s_in;
         logic signed [cscq_pkg::ANG_W-1:0] acc_p, fold_p, acc_in;
         logic signed [cscq_pkg::ANG_W:0]   resid;
         logic zero_p, quart_p, negs_p, negc_p;

         assign en[g] = ~v_ff[g] | en[g+1];

         // The first step starts from the unit vector on the cosine axis.
         if (g == 0) begin : g_first
            assign c_p     = cscq_pkg::ONE_Q14;
            assign s_p     = '0;
            assign acc_p   = '0;
            assign fold_p  = in_data.fold;
            assign zero_p  = in_data.fold == '0;
            assign quart_p = in_data.fold == cscq_pkg::QUARTER_S;
            assign negs_p  = in_data.neg_s;
            assign negc_p  = in_data.neg_c;
         end else begin : g_next
            assign c_p     = cos_ff[g-1];
            assign s_p     = sin_ff[g-1];
            assign acc_p   = acc_ff[g-1];
            assign fold_p  = fold_ff[g-1];
            assign zero_p  = zero_ff[g-1];
            assign quart_p = quart_ff[g-1];
            assign negs_p  = negs_ff[g-1];
            assign negc_p  = negc_ff[g-1];
         end

         // Rotate towards the residual angle; all vector sums wrap at 16 bits.
         assign resid = {fold_p[cscq_pkg::ANG_W-1], fold_p} - {acc_p[cscq_pkg::ANG_W-1], acc_p};
         assign cs    = c_p >>> g;
         assign ss    = s_p >>> g;

         always_comb begin
            if (resid[cscq_pkg::ANG_W]) begin
               s_in   = s_p - cs;
               c_in   = c_p + ss;
               acc_in = acc_p - cscq_pkg::atan_step(g);
            end else begin
               s_in   = s_p + cs;
               c_in   = c_p - ss;
               acc_in = acc_p + cscq_pkg::atan_step(g);
            end
         end

         always_ff @(posedge clock) begin
            if (en[g]) begin
               cos_ff[g]   <= c_in;
               sin_ff[g]   <= s_in;
               acc_ff[g]   <= acc_in;
               fold_ff[g]  <= fold_p;
               zero_ff[g]  <= zero_p;
               quart_ff[g] <= quart_p;
               negs_ff[g]  <= negs_p;
               negc_ff[g]  <= negc_p;
            end
         end
      end
   endgenerate

   assign out_valid           = v_ff[NI-1];
   assign out_data.cos_raw    = cos_ff[NI-1];
   assign out_data.sin_raw    = sin_ff[NI-1];
   assign out_data.is_zero    = zero_ff[NI-1];
   assign out_data.is_quarter = quart_ff[NI-1];
   assign out_data.neg_s      = negs_ff[NI-1];
   assign out_data.neg_c      = negc_ff[NI-1];

   // The residual of the last step is not needed further on.
   logic signed [cscq_pkg::ANG_W-1:0] unused_acc;
   logic signed [cscq_pkg::ANG_W-1:0] unused_fold;
   assign unused_acc  = acc_ff[NI-1];
   assign unused_fold = fold_ff[NI-1];

endmodule
`default_nettype wire

@@ rtl/cscq_gain.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cscq_gain: CORDIC gain correction and quadrant sign restore
//
// Two register stages: a rounded multiply by the inverse CORDIC gain, then
// the choice of exact results for the two special angles, the quadrant signs
// and the output register of the result channel.
// ----------------------------------------------------------------------------
module cscq_gain (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  cscq_pkg::rot_type               in_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [cscq_pkg::OUT_W-1:0] out_sine,
   output logic signed [cscq_pkg::OUT_W-1:0] out_cosine
);

   logic [1:0] v_ff;
   logic [1:0] v_in;
   logic [2:0] en;

   logic signed [32:0]                pc1_ff, ps1_ff;
   logic signed [32:0]                pc1_in, ps1_in;
   logic                              zero1_ff, quart1_ff, negs1_ff, negc1_ff;
   logic signed [cscq_pkg::OUT_W-1:0] c2_ff, s2_ff;
   logic signed [cscq_pkg::OUT_W-1:0] c_sel, s_sel, c2_in, s2_in;

   // Stage enables with bubble removal; the last stage is the output register.
   assign en[2]    = out_ready;
   assign en[1]    = ~v_ff[1] | en[2];
   assign en[0]    = ~v_ff[0] | en[1];
   assign v_in     = {v_ff[0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= v_in[0];
         end
         if (en[1]) begin
            v_ff[1] <= v_in[1];
         end
      end
   end

   // Rounded products; the sum never leaves 32 signed bits.
   assign pc1_in = in_data.cos_raw * $signed({1'b0, cscq_pkg::GAIN}) + cscq_pkg::GAIN_ROUND;
   assign ps1_in = in_data.sin_raw * $signed({1'b0, cscq_pkg::GAIN}) + cscq_pkg::GAIN_ROUND;

   // Exact values for zero and a quarter turn, then the quadrant signs.
   always_comb begin
      priority if (zero1_ff) begin
         c_sel = cscq_pkg::ONE_Q14;
         s_sel = '0;
      end else if (quart1_ff) begin
         c_sel = '0;
         s_sel = cscq_pkg::ONE_Q14;
      end else begin
         c_sel = pc1_ff[31:16];
         s_sel = ps1_ff[31:16];
      end
      c2_in = negc1_ff ? -c_sel : c_sel;
      s2_in = negs1_ff ? -s_sel : s_sel;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pc1_ff    <= pc1_in;
         ps1_ff    <= ps1_in;
         zero1_ff  <= in_data.is_zero;
         quart1_ff <= in_data.is_quarter;
         negs1_ff  <= in_data.neg_s;
         negc1_ff  <= in_data.neg_c;
      end
      if (en[1]) begin
         c2_ff <= c2_in;
         s2_ff <= s2_in;
      end
   end

   assign out_valid  = v_ff[1];
   assign out_sine   = s2_ff;
   assign out_cosine = c2_ff;

   // The top bit and low half of each product are dropped by the shift.
   logic [33:0] unused_bits;
   assign unused_bits = {pc1_ff[32], ps1_ff[32], pc1_ff[15:0], ps1_ff[15:0]};

endmodule
`default_nettype wire

@@ rtl/cordic_sine_cosine_q14_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_sine_cosine_q14_core: pipelined CORDIC sine and cosine in Q14
//
// Takes a signed 32-bit angle (one period is ANGLE_PERIOD units, 4096 units
// per radian by default) and returns sine and cosine in Q14, where 16384 is
// one. The angle is reduced modulo the period and folded into the first
// quadrant; zero and a quarter turn give exact results, other angles run the
// CORDIC rotation steps, a rounded gain correction and the quadrant signs.
// The block accepts one beat per clock cycle and returns one result beat per
// input beat, in order. The pipeline has six stages of period reduction and
// folding, one stage per rotation step and two for gain correction and sign
// restore. Back-pressure on the result side stalls only the full part of the
// pipeline; empty stages still take beats.
// ----------------------------------------------------------------------------
module cordic_sine_cosine_q14_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [15:0] sine_q14, [31:16] cosine_q14
);

   logic              red_valid, red_ready;
   cscq_pkg::red_type red_data;
   logic              rot_valid, rot_ready;
   cscq_pkg::rot_type rot_data;
   logic signed [cscq_pkg::OUT_W-1:0] sine_q14, cosine_q14;

   // Period reduction and quadrant fold.
   cscq_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_angle  ($signed(req_tdata)),
      .out_valid (red_valid),
      .out_ready (red_ready),
      .out_data  (red_data)
   );

   // Rotation steps.
   cscq_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_valid),
      .in_ready  (red_ready),
      .in_data   (red_data),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_data  (rot_data)
   );

   // Gain correction, signs and the result register.
   cscq_gain u_gain (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rot_valid),
      .in_ready   (rot_ready),
      .in_data    (rot_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sine   (sine_q14),
      .out_cosine (cosine_q14)
   );

   assign rsp_tdata = {cosine_q14, sine_q14};

`ifndef ASSERT_OFF
   // With no result waiting, the pipeline can always take a new beat.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while no result is pending");

   // The fold always lands in the first quadrant.
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      red_valid |-> (red_data.fold >= 0) && (red_data.fold <= cscq_pkg::QUARTER_S))
      else $error("folded angle outside the first quadrant");

   // An angle cannot be both exact cases at once.
   a_special_excl: assert property (@(posedge clock) disable iff (reset)
      rot_valid |-> !(rot_data.is_zero && rot_data.is_quarter))
      else $error("zero and quarter turn flagged together");
`endif

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pipelined CORDIC sine/cosine core
//
// Angles are offered on the request stream in bursts of random length with
// random gaps. Each accepted angle is turned into an expected sine/cosine pair
// by a bit-exact predictor. The result stream is stalled on a pattern of its
// own, with one long hold-off so that the pipeline fills and stalls its input.
// Every result beat is compared, field by field, with the oldest expected pair.
// ----------------------------------------------------------------------------
module tb_top;

   // Pipeline depth given for the core, plus a margin for the final drain.
   localparam int PIPE_LATENCY = 6 + cscq_pkg::ITERATIONS + 2;
   localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY + 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BEATS = 1850;

   // Angle constants at bench width.
   localparam int PERIOD  = cscq_pkg::ANGLE_PERIOD;
   localparam int HALF    = cscq_pkg::ANGLE_HALF;
   localparam int QUARTER = cscq_pkg::ANGLE_QUARTER;

   // Gain correction constant and the rounding half in Q16.
   localparam int GAIN_Q16  = 'h9b75;
   localparam int ROUND_Q16 = 'h8000;

   // Arctangent of 2^-i in angle units.
   localparam int ATAN_STEP [0:12] = '{3217, 1899, 1003, 509, 256, 128, 64,
                                       32, 16, 8, 4, 2, 1};

   // One expected result, with the angle that caused it for the report line.
   typedef struct {
      logic [31:0]        angle;
      logic signed [15:0] sine;
      logic signed [15:0] cosine;
   } sincos_type;

   // ------------------------------------------------------------------------
   // Expected sine/cosine pairs, in the order the angles were accepted.
   // ------------------------------------------------------------------------
   class sincos_tracker;
      sincos_type pending_sincos[$];
      int         mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      // Bit-exact sine and cosine of one angle.
      function sincos_type predict_sincos(logic [31:0] angle_bits);
         longint             a, mag, nabs, norm, fold, acc;
         logic signed [15:0] c, s, cs, ss;
         int                 gc, gs;
         sincos_type         r;
         a    = longint'($signed(angle_bits));
         mag  = (a < 0) ? -a : a;
         nabs = mag % longint'(PERIOD);
         // Map into the range from minus half to half a period.
         if (nabs <= longint'(HALF)) begin
            norm = (a < 1) ? -nabs : nabs;
         end else if (a < 0) begin
            norm = longint'(PERIOD) - nabs;
         end else begin
            norm = nabs - longint'(PERIOD);
         end
         // Fold into the first quadrant.
         if (norm <= longint'(QUARTER)) begin
            if (norm < -longint'(QUARTER)) begin
               fold = norm + longint'(HALF);
            end else begin
               fold = (norm < 0) ? -norm : norm;
            end
         end else begin
            fold = longint'(HALF) - norm;
         end
         // Exact ends of the quadrant, otherwise rotate and correct the gain.
         if (fold == 0) begin
            s = 16'sd0;
            c = 16'sh4000;
         end else if (fold == longint'(QUARTER)) begin
            s = 16'sh4000;
            c = 16'sd0;
         end else begin
            c   = 16'sh4000;
            s   = 16'sd0;
            acc = 0;
            for (int i = 0; i < cscq_pkg::ITERATIONS && i < 13; i++) begin
               cs = c >>> i;
               ss = s >>> i;
               if (fold - acc < 0) begin
                  cs  = -cs;
                  acc = acc - ATAN_STEP[i];
               end else begin
                  ss  = -ss;
                  acc = acc + ATAN_STEP[i];
               end
               s = s + cs;
               c = c + ss;
            end
            gc = int'(c) * GAIN_Q16 + ROUND_Q16;
            gs = int'(s) * GAIN_Q16 + ROUND_Q16;
            c  = 16'(gc >>> 16);
            s  = 16'(gs >>> 16);
         end
         // Restore the quadrant signs; negation wraps at 16 bits.
         if (norm <= longint'(QUARTER)) begin
            if (norm < -longint'(QUARTER)) begin
               c = -c;
               s = -s;
            end else if (norm < 0) begin
               s = -s;
            end
         end else begin
            c = -c;
         end
         r.angle  = angle_bits;
         r.sine   = s;
         r.cosine = c;
         return r;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH: %s", what);
         mismatch_count++;
      endtask

      function void note_angle(logic [31:0] angle_bits);
         pending_sincos.push_back(predict_sincos(angle_bits));
      endfunction

      task check_result(logic [31:0] data);
         sincos_type exp_sc;
         if (pending_sincos.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat %h", data));
         end else begin
            exp_sc = pending_sincos.pop_front();
            if (data[15:0] !== exp_sc.sine) begin
               report_mismatch($sformatf("angle %h sine %h, expected %h",
                                         exp_sc.angle, data[15:0], exp_sc.sine));
            end
            if (data[31:16] !== exp_sc.cosine) begin
               report_mismatch($sformatf("angle %h cosine %h, expected %h",
                                         exp_sc.angle, data[31:16], exp_sc.cosine));
            end
         end
      endtask

      function int pending();
         return pending_sincos.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] angle
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [15:0] sine_q14, [31:16] cosine_q14

   sincos_tracker sincos_sb;
   int            cycle_count;
   int            burst_left;

   cordic_sine_cosine_q14_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit, counted in cycles.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Compare every result beat taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sincos_sb.check_result(rsp_tdata);
      end
   end

   // Result-side back-pressure: changing stall modes and one long hold-off.
   initial begin
      int rx_cycles;
      int mode;
      int mode_left;
      rsp_tready = 1'b0;
      rx_cycles  = 0;
      mode       = 0;
      mode_left  = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         rx_cycles++;
         if (rx_cycles == 1200) begin
            // Long hold-off while the sender keeps offering angles.
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 120);
         end
         mode_left--;
         unique case (mode)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = ($urandom_range(0, 1) == 0);
            2:       rsp_tready = ($urandom_range(0, 7) != 0);
            default: rsp_tready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Offer one angle, held until accepted; returns at the next falling edge.
   task send_angle(logic [31:0] angle_bits);
      int gap;
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tdata  = angle_bits;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sincos_sb.note_angle(angle_bits);
      burst_left--;
      @(negedge clock);
   endtask

   // Random angle: full range, near zero, near quadrant edges, near the ends.
   function automatic logic [31:0] pick_angle();
      int k;
      int delta;
      unique case ($urandom_range(0, 4))
         0, 1: return $urandom;
         2:    return 32'($urandom_range(0, 6 * PERIOD)) - 32'(3 * PERIOD);
         3: begin
            k     = $urandom_range(0, 16) - 8;
            delta = $urandom_range(0, 6) - 3;
            return 32'(k * QUARTER + delta);
         end
         default: begin
            delta = $urandom_range(0, 200);
            return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 + 32'(delta)
                                               : 32'h7fff_ffff - 32'(delta);
         end
      endcase
   endfunction

   // Reset, directed angles, random angles, drain and verdict.
   initial begin
      logic [31:0] directed [] = '{
         32'd0, 32'(QUARTER), -32'(QUARTER), 32'(HALF),
         -32'(HALF), 32'(PERIOD), -32'(PERIOD),
         32'(3 * QUARTER), -32'(3 * QUARTER), 32'(HALF + 1),
         32'(HALF - 1), -32'(HALF + 1), 32'(QUARTER + 1),
         32'(QUARTER - 1), 32'd1, 32'hffff_ffff, 32'd2,
         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 32'(PERIOD - 1),
         32'(PERIOD + 1), 32'(PERIOD + QUARTER), 32'h5555_aaaa
      };
      sincos_sb  = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_angle(directed[i]);
      repeat (RANDOM_BEATS) send_angle(pick_angle());
      req_tvalid = 1'b0;

      // Drain: wait for every expected pair, then a little more for strays.
      while (sincos_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sincos_sb.pending() != 0) begin
         sincos_sb.report_mismatch("expected results left over");
      end
      if (sincos_sb.mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
